// File: rtl/core/ssrs_pkg.sv
// shared types, constants and word functions for the subset-sum reachable set unit
package ssrs_pkg;

  localparam int MaxSum   = 4095;
  localparam int WordBits = 64;
  localparam int NumWords = MaxSum / WordBits + 1;
  localparam int AddrW    = $clog2(NumWords);
  localparam int BitW     = $clog2(WordBits);
  localparam int SumW     = 12;
  localparam int CountW   = 13;
  localparam int ValW     = 16;

  typedef logic [WordBits-1:0] word_t;
  typedef logic [AddrW-1:0]    addr_t;
  typedef logic [BitW-1:0]     bit_t;
  typedef logic [SumW-1:0]     sum_t;
  typedef logic [CountW-1:0]   count_t;
  typedef logic [ValW-1:0]     val_t;

  // control from the sequencer to the result accumulator
  typedef struct packed {
    logic clear;
    logic valid;
    logic top;
  } tally_ctrl_t;

  // ones at bit positions 0 up to b
  function automatic word_t low_mask(bit_t b);
    return word_t'({WordBits{1'b1}} >> (bit_t'(WordBits - 1) - b));
  endfunction

  function automatic logic [BitW:0] popcount(word_t w);
    logic [BitW:0] n;
    n = '0;
    for (int i = 0; i < WordBits; i++) begin
      n = n + (BitW+1)'(w[i]);
    end
    return n;
  endfunction

  // index of the highest set bit, zero for an empty word
  function automatic bit_t msb_index(word_t w);
    bit_t idx;
    idx = '0;
    for (int i = 0; i < WordBits; i++) begin
      if (w[i]) begin
        idx = bit_t'(i);
      end
    end
    return idx;
  endfunction

endpackage

// File: rtl/core/ssrs_if.sv
// valid/ready channel interfaces for elements in and results out
interface ssrs_in_if;
  logic               valid;
  logic               ready;
  ssrs_pkg::val_t     element_value;
  logic               last_element;

  modport source (output valid, output element_value, output last_element, input ready);
  modport sink   (input valid, input element_value, input last_element, output ready);
endinterface

interface ssrs_out_if;
  logic               valid;
  logic               ready;
  logic               target_reachable;
  ssrs_pkg::sum_t     best_sum;
  ssrs_pkg::count_t   sum_count;

  modport source (output valid, output target_reachable, output best_sum, output sum_count,
                  input ready);
  modport sink   (input valid, input target_reachable, input best_sum, input sum_count,
                  output ready);
endinterface

// File: rtl/core/ssrs_bitmem.sv
// bitset word memory, two registered read ports, one write port, per-row valid bits
module ssrs_bitmem (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            clear_i,
  input  ssrs_pkg::addr_t rd_a_addr_i,
  input  ssrs_pkg::addr_t rd_b_addr_i,
  input  logic            wr_en_i,
  input  ssrs_pkg::addr_t wr_addr_i,
  input  ssrs_pkg::word_t wr_data_i,
  output ssrs_pkg::word_t rd_a_data_o,
  output ssrs_pkg::word_t rd_b_data_o
);
  import ssrs_pkg::*;

  word_t               mem [NumWords];
  logic [NumWords-1:0] row_valid_q;
  word_t               rd_a_q, rd_b_q;
  logic                vld_a_q, vld_b_q;
  logic                row0_a_q, row0_b_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_valid_q <= '0;
    end else if (clear_i) begin
      row_valid_q <= '0;
    end else if (wr_en_i) begin
      row_valid_q[wr_addr_i] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    rd_a_q   <= mem[rd_a_addr_i];
    rd_b_q   <= mem[rd_b_addr_i];
    vld_a_q  <= row_valid_q[rd_a_addr_i];
    vld_b_q  <= row_valid_q[rd_b_addr_i];
    row0_a_q <= (rd_a_addr_i == '0);
    row0_b_q <= (rd_b_addr_i == '0);
  end

  // a row never written since the last clear holds the empty set, sum zero in row zero
  assign rd_a_data_o = vld_a_q ? rd_a_q : word_t'(row0_a_q);
  assign rd_b_data_o = vld_b_q ? rd_b_q : word_t'(row0_b_q);

endmodule

// File: rtl/core/ssrs_word_alu.sv
// shared funnel shift, bound mask and merge for one bitset word
module ssrs_word_alu (
  input  ssrs_pkg::word_t hi_i,
  input  ssrs_pkg::word_t lo_i,
  input  ssrs_pkg::word_t dest_i,
  input  logic            lo_zero_i,
  input  ssrs_pkg::bit_t  shamt_i,
  input  logic            top_i,
  input  ssrs_pkg::bit_t  top_bit_i,
  output ssrs_pkg::word_t word_o
);
  import ssrs_pkg::*;

  logic [2*WordBits-1:0] cat;
  word_t                 lo_eff;
  word_t                 mask;

  always_comb begin
    lo_eff = lo_zero_i ? '0 : lo_i;
    cat    = {hi_i, lo_eff} << shamt_i;
    mask   = top_i ? low_mask(top_bit_i) : '1;
    word_o = dest_i | (cat[2*WordBits-1:WordBits] & mask);
  end

endmodule

// File: rtl/core/ssrs_tally.sv
// accumulates count, largest sum and target bit over the scanned words
module ssrs_tally (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  ssrs_pkg::tally_ctrl_t ctrl_i,
  input  ssrs_pkg::addr_t       idx_i,
  input  ssrs_pkg::bit_t        top_bit_i,
  input  ssrs_pkg::word_t       word_i,
  output logic                  reachable_o,
  output ssrs_pkg::sum_t        best_o,
  output ssrs_pkg::count_t      count_o
);
  import ssrs_pkg::*;

  logic   reach_q;
  sum_t   best_q;
  count_t count_q;
  word_t  masked;

  assign masked = ctrl_i.top ? (word_i & low_mask(top_bit_i)) : word_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      reach_q <= 1'b0;
      best_q  <= '0;
      count_q <= '0;
    end else if (ctrl_i.clear) begin
      reach_q <= 1'b0;
      best_q  <= '0;
      count_q <= '0;
    end else if (ctrl_i.valid) begin
      count_q <= count_q + count_t'(popcount(masked));
      if (masked != '0) begin
        best_q <= {idx_i, msb_index(masked)};
      end
      if (ctrl_i.top) begin
        reach_q <= word_i[top_bit_i];
      end
    end
  end

  assign reachable_o = reach_q;
  assign best_o      = best_q;
  assign count_o     = count_q;

endmodule

// File: rtl/core/subset_sum_reachable_set_unit.sv
// subset-sum reachable set: sequencer over the word memory, shift unit and tally
// an element adding nothing skips the update; else it walks words bound/64 to value/64,
//   one bitset word per cycle through the shared shift unit and the memory write port
// a marked last element adds a scan of bound/64 + 1 words before the result
// one element in work at a time; ready only while idle, the result register frees the input
// reset: target 0, set holds only sum zero (row valid bits, no clearing pass), no result
module subset_sum_reachable_set_unit (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  ssrs_pkg::sum_t      cfg_wdata_i,
  ssrs_in_if.sink             elem_i,
  ssrs_out_if.source          result_o
);
  import ssrs_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PRIME,
    ST_UPD,
    ST_FLUSH,
    ST_SCAN,
    ST_SCAN_END,
    ST_DONE
  } state_e;

  state_e state_q;

  sum_t   target_q;
  sum_t   bound_q;
  addr_t  q_q;
  bit_t   r_q;
  logic   last_q;
  addr_t  w_q;

  // pending write stage of the update walk
  logic   p_valid_q;
  addr_t  p_w_q;
  logic   p_lozero_q;
  logic   p_top_q;

  // scan data stage
  logic   s_valid_q;
  addr_t  s_idx_q;
  logic   s_top_q;

  // previous source word, upper half of the funnel
  word_t  hi_q;

  // result register
  logic   out_valid_q;
  logic   out_reach_q;
  sum_t   out_best_q;
  count_t out_count_q;

  addr_t       rd_a_addr, rd_b_addr;
  word_t       rd_a_data, rd_b_data;
  word_t       alu_word;
  logic        mem_clear;
  logic        in_xfer;
  logic        skip;
  addr_t       bound_w;
  tally_ctrl_t tally_ctrl;
  logic        t_reach;
  sum_t        t_best;
  count_t      t_count;
  logic        out_free;

  assign bound_w  = bound_q[SumW-1:BitW];
  assign in_xfer  = elem_i.valid && elem_i.ready;
  assign elem_i.ready = (state_q == ST_IDLE);
  // zero or anything past the bound leaves the set as it is
  assign skip     = (elem_i.element_value == '0) ||
                    (elem_i.element_value > val_t'(target_q));
  assign out_free = !out_valid_q || result_o.ready;
  assign mem_clear = (state_q == ST_DONE) && out_free;

  // read addresses: source word ahead of the destination, both walking down
  always_comb begin
    rd_a_addr = '0;
    rd_b_addr = '0;
    unique case (state_q)
      ST_PRIME: rd_a_addr = addr_t'(bound_w - q_q);
      ST_UPD: begin
        rd_a_addr = addr_t'(w_q - q_q - 1'b1);
        rd_b_addr = w_q;
      end
      ST_SCAN: rd_a_addr = w_q;
      default: begin
        rd_a_addr = '0;
        rd_b_addr = '0;
      end
    endcase
  end

  ssrs_bitmem u_mem (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .clear_i     (mem_clear),
    .rd_a_addr_i (rd_a_addr),
    .rd_b_addr_i (rd_b_addr),
    .wr_en_i     (p_valid_q),
    .wr_addr_i   (p_w_q),
    .wr_data_i   (alu_word),
    .rd_a_data_o (rd_a_data),
    .rd_b_data_o (rd_b_data)
  );

  ssrs_word_alu u_alu (
    .hi_i      (hi_q),
    .lo_i      (rd_a_data),
    .dest_i    (rd_b_data),
    .lo_zero_i (p_lozero_q),
    .shamt_i   (r_q),
    .top_i     (p_top_q),
    .top_bit_i (bound_q[BitW-1:0]),
    .word_o    (alu_word)
  );

  always_comb begin
    tally_ctrl.clear = (state_q == ST_SCAN) && (w_q == '0);
    tally_ctrl.valid = s_valid_q;
    tally_ctrl.top   = s_top_q;
  end

  ssrs_tally u_tally (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      (tally_ctrl),
    .idx_i       (s_idx_q),
    .top_bit_i   (bound_q[BitW-1:0]),
    .word_i      (rd_a_data),
    .reachable_o (t_reach),
    .best_o      (t_best),
    .count_o     (t_count)
  );

  always_ff @(posedge clk_i) begin
    hi_q <= rd_a_data;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      target_q    <= '0;
      bound_q     <= '0;
      q_q         <= '0;
      r_q         <= '0;
      last_q      <= 1'b0;
      w_q         <= '0;
      p_valid_q   <= 1'b0;
      p_w_q       <= '0;
      p_lozero_q  <= 1'b0;
      p_top_q     <= 1'b0;
      s_valid_q   <= 1'b0;
      s_idx_q     <= '0;
      s_top_q     <= 1'b0;
      out_valid_q <= 1'b0;
      out_reach_q <= 1'b0;
      out_best_q  <= '0;
      out_count_q <= '0;
    end else begin
      if (cfg_we_i) begin
        target_q <= cfg_wdata_i;
      end

      p_valid_q <= (state_q == ST_UPD);
      s_valid_q <= (state_q == ST_SCAN);

      // result leaves on its transfer unless a new one loads the same edge
      if ((state_q == ST_DONE) && out_free) begin
        out_valid_q <= 1'b1;
      end else if (result_o.ready) begin
        out_valid_q <= 1'b0;
      end

      unique case (state_q)
        ST_IDLE: begin
          if (in_xfer) begin
            bound_q <= target_q;
            q_q     <= elem_i.element_value[SumW-1:BitW];
            r_q     <= elem_i.element_value[BitW-1:0];
            last_q  <= elem_i.last_element;
            w_q     <= '0;
            if (!skip) begin
              state_q <= ST_PRIME;
            end else if (elem_i.last_element) begin
              state_q <= ST_SCAN;
            end
          end
        end
        ST_PRIME: begin
          w_q     <= bound_w;
          state_q <= ST_UPD;
        end
        ST_UPD: begin
          p_w_q      <= w_q;
          p_lozero_q <= (w_q == q_q);
          p_top_q    <= (w_q == bound_w);
          if (w_q == q_q) begin
            state_q <= ST_FLUSH;
          end else begin
            w_q <= w_q - 1'b1;
          end
        end
        ST_FLUSH: begin
          w_q     <= '0;
          state_q <= last_q ? ST_SCAN : ST_IDLE;
        end
        ST_SCAN: begin
          s_idx_q <= w_q;
          s_top_q <= (w_q == bound_w);
          if (w_q == bound_w) begin
            state_q <= ST_SCAN_END;
          end else begin
            w_q <= w_q + 1'b1;
          end
        end
        ST_SCAN_END: begin
          state_q <= ST_DONE;
        end
        ST_DONE: begin
          if (out_free) begin
            out_reach_q <= t_reach;
            out_best_q  <= t_best;
            out_count_q <= t_count;
            state_q     <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign result_o.valid            = out_valid_q;
  assign result_o.target_reachable = out_reach_q;
  assign result_o.best_sum         = out_best_q;
  assign result_o.sum_count        = out_count_q;

endmodule
